@@ rtl/core/tser_pkg.sv @@
package tser_pkg;

  // Capture counter width used for ranging (at most the 16-bit field width).
  localparam int COUNT_WIDTH = 16;
  localparam int CNT_W       = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;

  localparam int PERIOD_W      = 8;
  localparam int SENSOR_W      = 2;
  localparam int NUM_SENSORS   = 3;
  localparam int DIST_W        = 11;
  localparam int CAP_W         = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd40;

  // distance = floor(count * 17 / 1000) = (count * ceil(17 * 2^31 / 1000)) >> 31,
  // exact for every count below 2^16.
  localparam int DIST_SHIFT   = 31;
  localparam int DIST_MULT_W  = 26;
  localparam logic [DIST_MULT_W-1:0] DIST_MULT = 26'd36507223;
  localparam int PROD_W       = DIST_SHIFT + DIST_W;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_DIST  = 2'd2,
    KIND_TRIG  = 2'd3
  } kind_t;

  typedef enum logic [SENSOR_W-1:0] {
    SENSOR_CENTER = 2'd0,
    SENSOR_LEFT   = 2'd1,
    SENSOR_RIGHT  = 2'd2
  } sensor_t;

endpackage

@@ rtl/core/tser_dist.sv @@
module tser_dist (
  input  logic [tser_pkg::CNT_W-1:0]  count,
  output logic [tser_pkg::DIST_W-1:0] distance_cm
);
  import tser_pkg::*;

  logic [PROD_W-1:0] prod;

  // single constant multiply; the scaled reciprocal folds in the 17/1000
  assign prod        = PROD_W'(count) * PROD_W'(DIST_MULT);
  assign distance_cm = prod[DIST_SHIFT +: DIST_W];

endmodule

@@ rtl/core/three_sensor_echo_ranging_sequencer.sv @@
// Round-robin sequencer for three ultrasonic echo ranging sensors
// (center, left, right).
// Input channel (in_valid / in_stall): one word per event, either a 1 ms
// tick (in_operation = 0) or an echo capture edge (in_operation = 1) for
// in_sensor with the microsecond count in in_captured_count.
// Result channel (out_valid / out_stall): exactly one word per input word:
// nothing, clear capture counter, distance ready, or trigger sensor.
// Config: cfg_wr_en / cfg_wr_data write the trigger period in ms; write it
// only while no word is in flight.
// Throughput: one word per cycle while out_stall does not hold a full
// result register; the input register feeds one pass of decode logic
// and a constant multiply into the result register.
// Stall: when out_stall holds a full result register, a full input
// register holds too, in_stall rises in the same cycle; nothing drops.
// Reset (rst_n low, synchronous): pipeline empty, ms counter zero, sensor
// index at center (so the first trigger goes to left), all echo flags
// clear, trigger period back to 40 ms.
module three_sensor_echo_ranging_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  // config
  input  logic                          cfg_wr_en,
  input  logic [tser_pkg::PERIOD_W-1:0] cfg_wr_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_operation,
  input  logic [tser_pkg::SENSOR_W-1:0] in_sensor,
  input  logic [tser_pkg::CAP_W-1:0]    in_captured_count,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_result_kind,
  output logic [tser_pkg::SENSOR_W-1:0] out_result_sensor,
  output logic [tser_pkg::DIST_W-1:0]   out_distance_cm
);
  import tser_pkg::*;

  // ---- input register ----
  logic                   a_valid_r;
  logic                   a_op_r;
  logic [SENSOR_W-1:0]    a_sensor_r;
  logic [CNT_W-1:0]       a_count_r;

  // ---- result register ----
  logic                   out_valid_r;
  kind_t                  out_kind_r, out_kind_nxt;
  logic [SENSOR_W-1:0]    out_sensor_r, out_sensor_nxt;
  logic [DIST_W-1:0]      out_dist_r, out_dist_nxt;

  // ---- sequencer state ----
  logic [PERIOD_W-1:0]    period_r;
  logic [PERIOD_W-1:0]    ms_count_r, ms_count_nxt;
  logic [SENSOR_W-1:0]    cur_sensor_r, cur_sensor_nxt;
  logic [NUM_SENSORS-1:0] await_r, await_nxt;

  logic                   out_adv;   // result register can take a new word
  logic                   a_fire;    // input register word moves on
  logic                   in_fire;
  logic [PERIOD_W:0]      ms_inc;
  logic [SENSOR_W-1:0]    sensor_adv;
  logic [DIST_W-1:0]      dist_cm;

  assign out_adv  = !out_valid_r || !out_stall;
  assign a_fire   = a_valid_r && out_adv;
  assign in_stall = a_valid_r && !out_adv;
  assign in_fire  = in_valid && !in_stall;

  tser_dist u_dist (
    .count       (a_count_r),
    .distance_cm (dist_cm)
  );

  always_comb begin
    ms_inc     = {1'b0, ms_count_r} + 1'b1;
    sensor_adv = (cur_sensor_r == SENSOR_RIGHT) ? SENSOR_CENTER
                                                : cur_sensor_r + 1'b1;
  end

  // One pass over the held word: next sequencer state and the result.
  always_comb begin
    ms_count_nxt   = ms_count_r;
    cur_sensor_nxt = cur_sensor_r;
    await_nxt      = await_r;
    out_kind_nxt   = KIND_NONE;
    out_sensor_nxt = '0;
    out_dist_nxt   = '0;
    if (!a_op_r) begin
      // ms tick: trigger once the period is reached (or already passed)
      if (ms_inc >= {1'b0, period_r}) begin
        ms_count_nxt              = '0;
        cur_sensor_nxt            = sensor_adv;
        await_nxt[sensor_adv]     = 1'b0;
        out_kind_nxt              = KIND_TRIG;
        out_sensor_nxt            = sensor_adv;
      end else begin
        ms_count_nxt = ms_inc[PERIOD_W-1:0];
      end
    end else if (a_sensor_r < SENSOR_W'(NUM_SENSORS)) begin
      // echo edges alternate: first clears the counter, second ranges
      out_sensor_nxt = a_sensor_r;
      if (!await_r[a_sensor_r]) begin
        await_nxt[a_sensor_r] = 1'b1;
        out_kind_nxt          = KIND_CLEAR;
      end else begin
        await_nxt[a_sensor_r] = 1'b0;
        out_kind_nxt          = KIND_DIST;
        out_dist_nxt          = dist_cm;
      end
    end
    // unused sensor code: capture edge dropped, a KIND_NONE word reported
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      period_r     <= PERIOD_RESET;
      ms_count_r   <= '0;
      cur_sensor_r <= SENSOR_CENTER;
      await_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (a_fire) begin
        a_valid_r <= 1'b0;
      end
      if (out_adv) begin
        out_valid_r <= a_valid_r;
      end
      if (a_fire) begin
        ms_count_r   <= ms_count_nxt;
        cur_sensor_r <= cur_sensor_nxt;
        await_r      <= await_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op_r     <= in_operation;
      a_sensor_r <= in_sensor;
      a_count_r  <= in_captured_count[CNT_W-1:0];
    end
    if (a_fire) begin
      out_kind_r   <= out_kind_nxt;
      out_sensor_r <= out_sensor_nxt;
      out_dist_r   <= out_dist_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_result_sensor = out_sensor_r;
  assign out_distance_cm   = out_dist_r;

endmodule

@@ rtl/core/tser_checker.sv @@
module tser_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_result_kind,
  input logic [tser_pkg::SENSOR_W-1:0] out_result_sensor,
  input logic [tser_pkg::DIST_W-1:0]   out_distance_cm
);
  import tser_pkg::*;

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind)
      && $stable(out_result_sensor) && $stable(out_distance_cm))
    else $error("stalled result word changed");

  // sync reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // distance only carried by a distance word, never for a non-sensor
  a_dist_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != KIND_DIST |-> out_distance_cm == '0)
    else $error("distance on non-distance word");

  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == KIND_NONE |-> out_result_sensor == '0)
    else $error("sensor set on empty result");

  a_sensor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result_sensor != SENSOR_W'(3))
    else $error("result names no sensor");

endmodule

bind three_sensor_echo_ranging_sequencer tser_checker u_tser_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_kind   (out_result_kind),
  .out_result_sensor (out_result_sensor),
  .out_distance_cm   (out_distance_cm)
);
